/* rtl/core/ezas_pkg.sv */
// shared constants, types and helpers for the encoder zero-align sequencer
// no dependencies; used by every module under rtl/core
package ezas_pkg;

  localparam int unsigned POLE_PAIRS = 4;
  localparam int unsigned ANGLE_STEP = 2 * POLE_PAIRS;

  localparam int unsigned ANG_W = 9;
  localparam int unsigned TICK_W = 9;
  localparam int unsigned CUR_W = 16;
  localparam int unsigned ACC_W = 24;
  localparam int unsigned TOT_W = ACC_W + 2;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned FRAC_W = 14;
  // divider: dividend = total * 2^(FRAC_W+1) + 3*s, divisor = 6*s
  localparam int unsigned NUM_W = TOT_W + FRAC_W + 2;
  localparam int unsigned DEN_W = ACC_W + 3;
  localparam int unsigned REM_W = DEN_W + 1;
  localparam int unsigned ACC_CNT_W = $clog2(ACC_W + 1);
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int unsigned LANES = 3;

  localparam logic [TICK_W-1:0] T_ALIGN1 = TICK_W'(50);
  localparam logic [TICK_W-1:0] T_SWEEP_END = TICK_W'(180 + 50);
  localparam logic [TICK_W-1:0] T_ALIGN2 = TICK_W'(180 + 50 + 50);
  localparam logic [TICK_W-1:0] T_DONE = TICK_W'(180 + 60 + 50);

  localparam logic [ANG_W-1:0] MARK_LO = ANG_W'(150);
  localparam logic [ANG_W-1:0] MARK_HI = ANG_W'(210);
  localparam logic [ANG_W:0] ANGLE_FULL = (ANG_W + 1)'(360);

  localparam logic [1:0] DRIVE_NONE = 2'd0;
  localparam logic [1:0] DRIVE_HALF = 2'd1;
  localparam logic [1:0] DRIVE_FULL = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  typedef logic [ACC_W-1:0] sum_arr_t [LANES];

  typedef struct packed {
    logic load;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic              start;
    logic [TOT_W-1:0]  total;
    logic [ACC_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] gain;
  } div_rsp_t;

  function automatic logic [CUR_W-1:0] abs_cur(input logic [CUR_W-1:0] x);
    logic [CUR_W-1:0] neg;
    neg = (~x) + CUR_W'(1);
    return x[CUR_W-1] ? neg : x;
  endfunction

endpackage

/* rtl/core/encoder_zero_align_sequencer_unit.sv */
// encoder zero-align sequencer top level, depends on ezas_pkg, ezas_serial_acc, ezas_serial_div
// flow: an accepted word goes to the result register through the emit state; on ticks 51-229
// it first waits for the bit-serial accumulate, on tick 230 for the shared divider, one gain
// after another (a zero sum skips the division and gives full scale); the next word is taken
// only after the result loads, and a stalled result holds off the input
// reset: async active low; idle, gains 1.0 (16384), all else zero but the result payload
module encoder_zero_align_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] start_req, [9:1] encoder_angle, [25:10] phase_a_current,
  // [41:26] phase_b_current, [57:42] phase_c_current, [63:58] zero
  input  logic [63:0] s_axis_tdata,
  // result word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] active, [2:1] drive_level, [11:3] forced_angle, [20:12] zero_offset,
  // [21] direction, [37:22] gain_a, [53:38] gain_b, [69:54] gain_c,
  // [70] aligned, [71] finished
  output logic [71:0] m_axis_tdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e state_q;

  // unpacked input word
  logic                          in_start;
  logic [ezas_pkg::ANG_W-1:0]    in_angle;
  logic [ezas_pkg::CUR_W-1:0]    in_cur_a, in_cur_b, in_cur_c;
  logic                          in_acc;

  assign in_start = s_axis_tdata[0];
  assign in_angle = s_axis_tdata[9:1];
  assign in_cur_a = s_axis_tdata[25:10];
  assign in_cur_b = s_axis_tdata[41:26];
  assign in_cur_c = s_axis_tdata[57:42];

  // sequencer registers
  logic [ezas_pkg::TICK_W-1:0]   tick_q;
  logic [ezas_pkg::ANG_W-1:0]    fa_q;
  logic [1:0]                    drive_q;
  logic [ezas_pkg::ANG_W-1:0]    mark_q;
  logic                          decided_q;
  logic                          rev_q;
  logic [ezas_pkg::ANG_W-1:0]    zoff_q;
  logic                          dir_q;
  logic [ezas_pkg::GAIN_W-1:0]   gain_q [ezas_pkg::LANES];
  logic                          act_q, aligned_q, fin_q;
  logic [ezas_pkg::TOT_W-1:0]    total_q;
  logic [1:0]                    gidx_q;
  logic                          div_run_q;
  logic                          m_valid_q;
  logic [71:0]                   m_data_q;

  logic                          accept;
  logic                          run;
  logic [ezas_pkg::TICK_W-1:0]   tick_inc;
  logic [ezas_pkg::ANG_W:0]      fa_sum;
  logic [ezas_pkg::ANG_W-1:0]    fa_step;
  logic [ezas_pkg::ANG_W-1:0]    mark_new;
  logic                          sweep;
  logic                          gain_last;
  logic                          emit_load;

  ezas_pkg::acc_ctrl_t acc_ctrl;
  ezas_pkg::sum_arr_t  sums;
  logic                acc_busy;
  ezas_pkg::div_req_t  div_req;
  ezas_pkg::div_rsp_t  div_rsp;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    run      = (tick_q != '0) || in_start;
    tick_inc = tick_q + ezas_pkg::TICK_W'(1);
    sweep    = run && (tick_inc > ezas_pkg::T_ALIGN1) && (tick_inc < ezas_pkg::T_SWEEP_END);
    in_acc   = accept && sweep;
    // forced angle wraps into 1..360
    fa_sum   = {1'b0, fa_q} + (ezas_pkg::ANG_W + 1)'(ezas_pkg::ANGLE_STEP);
    fa_step  = (fa_sum > ezas_pkg::ANGLE_FULL) ? ezas_pkg::ANG_W'(fa_sum - ezas_pkg::ANGLE_FULL)
                                               : fa_sum[ezas_pkg::ANG_W-1:0];
    // first angle inside the mid window becomes the direction mark
    mark_new = (in_angle > ezas_pkg::MARK_LO && in_angle < ezas_pkg::MARK_HI
                && mark_q == '0 && !decided_q) ? in_angle : mark_q;
    gain_last = div_rsp.done && (gidx_q == 2'd2);
    emit_load = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready);
  end

  assign acc_ctrl = '{load: in_acc, clear: ((state_q == S_DIV) && gain_last)};

  assign div_req = '{start: ((state_q == S_DIV) && !div_run_q), total: total_q,
                     divisor: sums[gidx_q]};

  ezas_serial_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .cur_a_i (in_cur_a),
    .cur_b_i (in_cur_b),
    .cur_c_i (in_cur_c),
    .sums_o  (sums),
    .busy_o  (acc_busy)
  );

  ezas_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // tick decode and per-tick register updates happen at accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tick_q    <= '0;
      fa_q      <= '0;
      drive_q   <= ezas_pkg::DRIVE_NONE;
      mark_q    <= '0;
      decided_q <= 1'b0;
      rev_q     <= 1'b0;
      zoff_q    <= '0;
      dir_q     <= 1'b0;
      for (int i = 0; i < ezas_pkg::LANES; i++) begin
        gain_q[i] <= ezas_pkg::GAIN_ONE;
      end
      act_q     <= 1'b0;
      aligned_q <= 1'b0;
      fin_q     <= 1'b0;
      total_q   <= '0;
      gidx_q    <= '0;
      div_run_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      // result register: load from the emit state, drop once taken
      if (emit_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            // status flags follow the tick this word advances to
            act_q     <= run && (tick_inc < ezas_pkg::T_DONE);
            aligned_q <= run && (tick_inc == ezas_pkg::T_ALIGN2);
            fin_q     <= run && (tick_inc >= ezas_pkg::T_DONE);
            if (sweep) begin
              state_q <= S_ACC;
            end else if (run && (tick_inc == ezas_pkg::T_SWEEP_END)) begin
              state_q <= S_PREP;
            end else begin
              state_q <= S_EMIT;
            end
            if (run) begin
              // tick count clears at end of run
              tick_q <= (tick_inc >= ezas_pkg::T_DONE) ? '0 : tick_inc;
              priority if (tick_inc < ezas_pkg::T_ALIGN1) begin
                fa_q    <= '0;
                drive_q <= ezas_pkg::DRIVE_FULL;
              end else if (tick_inc == ezas_pkg::T_ALIGN1) begin
                zoff_q <= in_angle;
              end else if (tick_inc < ezas_pkg::T_SWEEP_END) begin
                fa_q    <= fa_step;
                drive_q <= ezas_pkg::DRIVE_HALF;
                mark_q  <= mark_new;
                if (mark_new != '0 && mark_new != in_angle && !decided_q) begin
                  rev_q     <= (mark_new > in_angle);
                  decided_q <= 1'b1;
                end
              end else if (tick_inc == ezas_pkg::T_SWEEP_END) begin
                if (rev_q) begin
                  dir_q <= ~dir_q;
                end
              end else if (tick_inc < ezas_pkg::T_ALIGN2) begin
                fa_q    <= '0;
                drive_q <= ezas_pkg::DRIVE_FULL;
              end else if (tick_inc == ezas_pkg::T_ALIGN2) begin
                zoff_q <= in_angle;
              end else if (tick_inc < ezas_pkg::T_DONE) begin
                // hold until end of run
              end else begin
                fa_q      <= '0;
                drive_q   <= ezas_pkg::DRIVE_NONE;
                mark_q    <= '0;
                decided_q <= 1'b0;
                rev_q     <= 1'b0;
              end
            end
          end
        end
        S_ACC: begin
          if (!acc_busy) begin
            state_q <= S_EMIT;
          end
        end
        S_PREP: begin
          total_q   <= ezas_pkg::TOT_W'(sums[0]) + ezas_pkg::TOT_W'(sums[1])
                       + ezas_pkg::TOT_W'(sums[2]);
          gidx_q    <= '0;
          div_run_q <= 1'b0;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          if (!div_run_q) begin
            div_run_q <= 1'b1;
          end else if (div_rsp.done) begin
            gain_q[gidx_q] <= div_rsp.gain;
            div_run_q      <= 1'b0;
            gidx_q         <= gidx_q + 2'd1;
            if (gain_last) begin
              state_q <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // result word register, payload only
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      m_data_q <= {fin_q, aligned_q, gain_q[2], gain_q[1], gain_q[0], dir_q,
                   zoff_q, fa_q, drive_q, act_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // accumulator must be done before a new word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready |-> !acc_busy)
    else $error("accumulator busy while taking a new word");

  // divider only finishes while the gain phase waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV && div_run_q))
    else $error("divider result outside gain phase");

  // an end-of-run word leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && fin_q) |-> (tick_q == '0 && !decided_q && mark_q == '0))
    else $error("run state not cleared at finish");

  // forced angle stays within one turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fa_q} <= ezas_pkg::ANGLE_FULL)
    else $error("forced angle beyond full turn");

endmodule

/* rtl/core/ezas_serial_acc.sv */
// bit-serial accumulator for the three absolute phase-current sums
// depends on ezas_pkg
module ezas_serial_acc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ezas_pkg::acc_ctrl_t           ctrl_i,
  input  logic [ezas_pkg::CUR_W-1:0]    cur_a_i,
  input  logic [ezas_pkg::CUR_W-1:0]    cur_b_i,
  input  logic [ezas_pkg::CUR_W-1:0]    cur_c_i,
  output ezas_pkg::sum_arr_t            sums_o,
  output logic                          busy_o
);

  ezas_pkg::sum_arr_t                   sum_q;
  logic [ezas_pkg::CUR_W-1:0]           add_q [ezas_pkg::LANES];
  logic [ezas_pkg::LANES-1:0]           carry_q;
  logic [ezas_pkg::ACC_CNT_W-1:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ezas_pkg::LANES; i++) begin
        sum_q[i] <= '0;
        add_q[i] <= '0;
      end
      carry_q <= '0;
      cnt_q   <= '0;
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < ezas_pkg::LANES; i++) begin
        sum_q[i] <= '0;
      end
      cnt_q <= '0;
    end else if (ctrl_i.load) begin
      add_q[0] <= ezas_pkg::abs_cur(cur_a_i);
      add_q[1] <= ezas_pkg::abs_cur(cur_b_i);
      add_q[2] <= ezas_pkg::abs_cur(cur_c_i);
      carry_q  <= '0;
      cnt_q    <= ezas_pkg::ACC_CNT_W'(ezas_pkg::ACC_W);
    end else if (cnt_q != '0) begin
      // lsb first, sum rotates right through its full width
      for (int i = 0; i < ezas_pkg::LANES; i++) begin
        sum_q[i]   <= {sum_q[i][0] ^ add_q[i][0] ^ carry_q[i],
                       sum_q[i][ezas_pkg::ACC_W-1:1]};
        carry_q[i] <= (sum_q[i][0] & add_q[i][0]) | (sum_q[i][0] & carry_q[i])
                      | (add_q[i][0] & carry_q[i]);
        add_q[i]   <= {1'b0, add_q[i][ezas_pkg::CUR_W-1:1]};
      end
      cnt_q <= cnt_q - ezas_pkg::ACC_CNT_W'(1);
    end
  end

  assign sums_o = sum_q;
  assign busy_o = (cnt_q != '0);

endmodule

/* rtl/core/ezas_serial_div.sv */
// restoring divider, one quotient bit per cycle, saturating q2.14 gain
// depends on ezas_pkg
module ezas_serial_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ezas_pkg::div_req_t  req_i,
  output ezas_pkg::div_rsp_t  rsp_o
);

  logic [ezas_pkg::NUM_W-1:0]     num_q;
  logic [ezas_pkg::DEN_W-1:0]     den_q;
  logic [ezas_pkg::REM_W-1:0]     rem_q;
  logic [ezas_pkg::GAIN_W-1:0]    quo_q;
  logic                           ovf_q;
  logic [ezas_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           done_q;

  logic [ezas_pkg::REM_W-1:0]     rem_sh;
  logic                           qbit;
  logic [ezas_pkg::NUM_W-1:0]     num_init;
  logic [ezas_pkg::DEN_W-1:0]     den_init;

  always_comb begin
    num_init = ezas_pkg::NUM_W'({req_i.total, (ezas_pkg::FRAC_W + 1)'(0)})
               + ezas_pkg::NUM_W'({req_i.divisor, 1'b0})
               + ezas_pkg::NUM_W'(req_i.divisor);
    den_init = ezas_pkg::DEN_W'({req_i.divisor, 2'b00})
               + ezas_pkg::DEN_W'({req_i.divisor, 1'b0});
    rem_sh   = {rem_q[ezas_pkg::REM_W-2:0], num_q[ezas_pkg::NUM_W-1]};
    qbit     = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      quo_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        ovf_q <= 1'b0;
        if (req_i.divisor == '0) begin
          // empty sum: report full scale
          quo_q  <= ezas_pkg::GAIN_MAX;
          done_q <= 1'b1;
        end else begin
          num_q <= num_init;
          den_q <= den_init;
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= ezas_pkg::DIV_CNT_W'(ezas_pkg::NUM_W);
        end
      end else if (cnt_q != '0) begin
        rem_q <= qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
        num_q <= {num_q[ezas_pkg::NUM_W-2:0], 1'b0};
        quo_q <= {quo_q[ezas_pkg::GAIN_W-2:0], qbit};
        ovf_q <= ovf_q | quo_q[ezas_pkg::GAIN_W-1];
        cnt_q <= cnt_q - ezas_pkg::DIV_CNT_W'(1);
        if (cnt_q == ezas_pkg::DIV_CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o = '{done: done_q, gain: (ovf_q ? ezas_pkg::GAIN_MAX : quo_q)};

endmodule
